// ===== design/echo_accumulate_filter_peak_assert.svh =====
// assertion macros for the echo block
`ifndef ECHO_ACCUMULATE_FILTER_PEAK_ASSERT_SVH
`define ECHO_ACCUMULATE_FILTER_PEAK_ASSERT_SVH
`define EAFP_ASSERT_IMPL(lbl, cond, conc) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conc)) \
    else $error("assertion failed");
`define EAFP_ASSERT_NEXT(lbl, cond, conc) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conc)) \
    else $error("assertion failed");
`endif

// ===== design/eafp_pkg.sv =====
package eafp_pkg;
  localparam int MAX_SAMPLES_DEF = 8192;
  localparam int ACC_WIDTH_DEF = 24;
  localparam int TAP_COUNT = 30;
  localparam int COEF_W = 13;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_PULSE = 2'd1,
    KIND_ADD = 2'd2,
    KIND_PROC = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_ACTIVE = 2'd0,
    REG_SEARCH = 2'd1
  } reg_idx_t;

  typedef struct packed {
    kind_t kind;
    logic [15:0] sample;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_ADD_RD, ST_ADD_WAIT, ST_ADD_WR,
    ST_SUM_RD, ST_SUM, ST_DIV, ST_FIR_RD, ST_FIR_WAIT, ST_FIR_LOAD,
    ST_MAC, ST_MAC_END, ST_OUT
  } state_t;

  function automatic logic [COEF_W-1:0] tap_coef(input logic [4:0] j);
    logic [COEF_W-1:0] c;
    case (j)
      5'd0, 5'd29: c = 13'd292;
      5'd1, 5'd28: c = 13'd339;
      5'd2, 5'd27: c = 13'd466;
      5'd3, 5'd26: c = 13'd674;
      5'd4, 5'd25: c = 13'd954;
      5'd5, 5'd24: c = 13'd1297;
      5'd6, 5'd23: c = 13'd1689;
      5'd7, 5'd22: c = 13'd2111;
      5'd8, 5'd21: c = 13'd2544;
      5'd9, 5'd20: c = 13'd2966;
      5'd10, 5'd19: c = 13'd3357;
      5'd11, 5'd18: c = 13'd3697;
      5'd12, 5'd17: c = 13'd3969;
      5'd13, 5'd16: c = 13'd4158;
      5'd14, 5'd15: c = 13'd4255;
      default: c = '0;
    endcase
    return c;
  endfunction
endpackage

// ===== design/eafp_front.sv =====
module eafp_front (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  eafp_pkg::cmd_t s_cmd,
  output logic q_valid,
  input  logic q_ready,
  output eafp_pkg::cmd_t q_cmd
);
  import eafp_pkg::*;
  localparam int AW = $clog2(QUEUE_DEPTH);
  cmd_t mem [QUEUE_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic push, pop;

  assign s_tready = (cnt != (AW+1)'(QUEUE_DEPTH));
  assign push = s_tvalid && s_tready;
  assign q_valid = (cnt != '0);
  assign pop = q_valid && q_ready;
  assign q_cmd = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= s_cmd;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ===== design/eafp_back.sv =====
module eafp_back #(
  parameter int MAX_SAMPLES = eafp_pkg::MAX_SAMPLES_DEF,
  parameter int ACC_WIDTH = eafp_pkg::ACC_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  eafp_pkg::cmd_t q_cmd,
  input  logic [13:0] active_samples,
  input  logic [12:0] search_start,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [12:0] peak_index,
  output logic [23:0] peak_value,
  output logic [23:0] mean_level,
  output logic busy
);
  import eafp_pkg::*;
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int NW = AW + 1;
  localparam int SW = ACC_WIDTH + NW;
  localparam int PW = ACC_WIDTH + COEF_W;
  localparam int MW = PW + 5;
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

  logic [ACC_WIDTH-1:0] mem [MAX_SAMPLES];
  logic [ACC_WIDTH-1:0] rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [ACC_WIDTH-1:0] wr_data;
  logic wr_en;

  state_t state, state_next;
  logic [NW-1:0] n_len, wpos, idx;
  logic first_pulse;
  logic [15:0] smp;
  logic [SW-1:0] sum, rem;
  logic [ACC_WIDTH-1:0] mean, quo;
  logic [5:0] dcnt;
  logic [ACC_WIDTH-1:0] hist [TAP_COUNT];
  logic [4:0] tap;
  logic [PW-1:0] prod;
  logic [MW-1:0] acc;
  logic [MW-1:0] acc_fin;
  logic [MW-17:0] y;
  logic [MW-17:0] best_val;
  logic [AW-1:0] best_idx;
  logic [ACC_WIDTH-1:0] rect;
  logic [SW:0] rem_sh;
  logic [ACC_WIDTH:0] add_s;

  always_comb begin
    if (active_samples == '0) n_len = NW'(1);
    else if ({18'd0, active_samples} > 32'(MAX_SAMPLES)) n_len = NW'(MAX_SAMPLES);
    else n_len = NW'(active_samples);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign rect = (rd_data >= mean) ? rd_data - mean : mean - rd_data;
  assign add_s = {1'b0, rd_data} + (ACC_WIDTH+1)'(smp);
  assign rem_sh = {rem, quo[ACC_WIDTH-1]};
  assign acc_fin = acc + MW'(prod);
  assign y = acc_fin[MW-1:16];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) begin
        unique case (q_cmd.kind)
          KIND_CLEAR: state_next = ST_CLEAR;
          KIND_PULSE: state_next = ST_IDLE;
          KIND_ADD: state_next = (wpos < n_len) ? ST_ADD_RD : ST_IDLE;
          default: state_next = ST_SUM_RD;
        endcase
      end
      ST_CLEAR: if (idx == NW'(MAX_SAMPLES - 1)) state_next = ST_IDLE;
      ST_ADD_RD: state_next = ST_ADD_WAIT;
      ST_ADD_WAIT: state_next = ST_ADD_WR;
      ST_ADD_WR: state_next = ST_IDLE;
      ST_SUM_RD: state_next = ST_SUM;
      ST_SUM: if (idx == n_len) state_next = ST_DIV;
      ST_DIV: if (dcnt == 6'(ACC_WIDTH)) state_next = ST_FIR_RD;
      ST_FIR_RD: state_next = ST_FIR_WAIT;
      ST_FIR_WAIT: state_next = ST_FIR_LOAD;
      ST_FIR_LOAD: state_next = ST_MAC;
      ST_MAC: if (tap == 5'(TAP_COUNT - 1)) state_next = ST_MAC_END;
      ST_MAC_END: state_next = (idx == n_len - NW'(1)) ? ST_OUT : ST_FIR_RD;
      ST_OUT: if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == ST_IDLE);
    m_tvalid = (state == ST_OUT);
    busy = (state != ST_IDLE) || q_valid;
    wr_en = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = '0;
    rd_addr = idx[AW-1:0];
    unique case (state)
      ST_CLEAR: wr_en = 1'b1;
      ST_ADD_WR: begin
        wr_en = 1'b1;
        wr_data = add_s[ACC_WIDTH] ? ACC_MAX : add_s[ACC_WIDTH-1:0];
      end
      ST_FIR_LOAD: begin
        wr_en = 1'b1;
        wr_data = rect;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PW'(hist[tap]) * PW'(tap_coef(tap));
    if (rst) idx <= '0;
    else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid && q_cmd.kind == KIND_ADD) begin
            idx <= wpos;
            smp <= q_cmd.sample;
          end else idx <= '0;
          sum <= '0;
        end
        ST_CLEAR: idx <= idx + 1'b1;
        ST_SUM_RD: idx <= idx + 1'b1;
        ST_SUM: begin
          sum <= sum + SW'(rd_data);
          idx <= idx + 1'b1;
          rem <= '0;
          dcnt <= '0;
        end
        ST_DIV: begin
          if (dcnt == '0) begin
            quo <= sum[ACC_WIDTH-1:0];
            rem <= SW'(sum >> ACC_WIDTH);
          end else begin
            quo <= {quo[ACC_WIDTH-2:0], 1'b0};
            if (rem_sh >= (SW+1)'(n_len)) begin
              rem <= SW'(rem_sh - (SW+1)'(n_len));
              quo[0] <= 1'b1;
            end else rem <= rem_sh[SW-1:0];
          end
          dcnt <= dcnt + 1'b1;
          idx <= '0;
          for (int k = 0; k < TAP_COUNT; k++) hist[k] <= '0;
          best_val <= '0;
          best_idx <= '0;
        end
        ST_FIR_LOAD: begin
          hist[0] <= rect;
          for (int k = 1; k < TAP_COUNT; k++) hist[k] <= hist[k-1];
          tap <= '0;
          acc <= '0;
        end
        ST_MAC: begin
          tap <= tap + 1'b1;
          if (tap != '0) acc <= acc + MW'(prod);
        end
        ST_MAC_END: begin
          if (32'(idx) >= 32'(search_start) && y > best_val) begin
            best_val <= y;
            best_idx <= idx[AW-1:0];
          end
          idx <= idx + 1'b1;
        end
        default: ;
      endcase
    end
    if (state == ST_FIR_RD) mean <= quo;
    if (rst) begin
      state <= ST_CLEAR;
      wpos <= '0;
      first_pulse <= 1'b1;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && q_valid) begin
        unique case (q_cmd.kind)
          KIND_CLEAR: begin wpos <= '0; first_pulse <= 1'b1; end
          KIND_PULSE: begin wpos <= '0; first_pulse <= 1'b0; end
          KIND_ADD: if (wpos < n_len) wpos <= wpos + 1'b1;
          default: ;
        endcase
      end
    end
  end

  assign peak_index = 13'(best_idx);
  assign peak_value = best_val > (MW-16)'(24'hFFFFFF) ? 24'hFFFFFF : 24'(best_val);
  assign mean_level = (32'(mean) > 32'hFFFFFF) ? 24'hFFFFFF : 24'(mean);
endmodule

// ===== design/echo_accumulate_filter_peak.sv =====
// Add sample: read, wait and write states; ignored add and next pulse: taken in idle;
// clear: a pass over all MAX_SAMPLES entries. Process: one summing pass, a bit-serial
// division, then per sample a read, a load and a pass over the 30-tap shared multiplier.
// Items are queued in a four-entry input queue while the back end works.
// Synchronous active-high reset, then a clear pass zeroes the record.
module echo_accumulate_filter_peak #(
  parameter int MAX_SAMPLES = eafp_pkg::MAX_SAMPLES_DEF,
  parameter int ACC_WIDTH = eafp_pkg::ACC_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [15:0] s_tdata,  // sample
  input  logic [1:0] s_tuser,   // kind
  output logic m_tvalid,
  input  logic m_tready,
  output logic [63:0] m_tdata,  // peak_index, peak_value, mean_level, zero fill
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import eafp_pkg::*;
  cmd_t s_cmd, q_cmd;
  logic q_valid, q_ready, busy;
  logic [13:0] active_samples;
  logic [12:0] search_start;
  logic [12:0] peak_index;
  logic [23:0] peak_value, mean_level;

  assign s_cmd.kind = kind_t'(s_tuser);
  assign s_cmd.sample = s_tdata;
  assign cfg_ready = 1'b1;
  assign m_tdata = {3'd0, mean_level, peak_value, peak_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      active_samples <= 14'd5000;
      search_start <= 13'd1000;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ACTIVE) active_samples <= cfg_data[13:0];
      else if (cfg_index == REG_SEARCH) search_start <= cfg_data[12:0];
    end
  end

  eafp_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_cmd, .q_valid, .q_ready, .q_cmd
  );

  eafp_back #(.MAX_SAMPLES(MAX_SAMPLES), .ACC_WIDTH(ACC_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .active_samples, .search_start,
    .m_tvalid, .m_tready, .peak_index, .peak_value, .mean_level, .busy
  );

  `include "echo_accumulate_filter_peak_assert.svh"
  `EAFP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `EAFP_ASSERT_IMPL(a_no_pop_busy, q_ready, !m_tvalid)
  `EAFP_ASSERT_IMPL(a_busy_out, m_tvalid, busy)
endmodule
